// ----- hw/rtl/aad_pkg.sv -----
package aad_pkg;

    localparam int MAX_SRC_W   = 2048;
    localparam int MAX_SRC_H   = 2048;
    localparam int MAX_DST_W   = 512;
    localparam int MAX_DST_H   = 512;

    localparam int SUM_W       = 30;
    localparam int CNT_W       = 24;
    localparam int SPOS_W      = 11;
    localparam int DPOS_W      = 9;
    localparam int SSIZE_W     = 12;
    localparam int DSIZE_W     = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int FMT_W       = 3;
    localparam int INIT_STEPS  = SSIZE_W;
    localparam int DIV_STEPS   = SUM_W;
    localparam int INIT_CNT_W  = $clog2(INIT_STEPS + 1);
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam logic [7:0] OPAQUE = 8'd255;

    typedef enum logic [FMT_W-1:0] {
        FMT_RGB  = 3'd0,
        FMT_RGBA = 3'd1,
        FMT_BGRA = 3'd2,
        FMT_RGBX = 3'd3,
        FMT_BGRX = 3'd4
    } fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_FORMAT = 3'd0,
        REG_SRC_WIDTH    = 3'd1,
        REG_SRC_HEIGHT   = 3'd2,
        REG_DST_WIDTH    = 3'd3,
        REG_DST_HEIGHT   = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ACC,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
    } pix_t;

    typedef struct packed {
        logic [7:0]        out_red;
        logic [7:0]        out_green;
        logic [7:0]        out_blue;
        logic [7:0]        out_alpha;
        logic [DPOS_W-1:0] out_x;
        logic [DPOS_W-1:0] out_y;
        logic              frame_end;
    } res_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_t;

endpackage

// ----- hw/rtl/aad_ifs.sv -----
interface aad_pix_if import aad_pkg::*; ();
    logic valid;
    logic ready;
    pix_t data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface aad_res_if import aad_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface aad_cfg_if import aad_pkg::*; ();
    logic valid;
    logic ready;
    cfg_t data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

// ----- hw/rtl/area_average_downscaler.sv -----
// A beat that closes a box is read, accumulated, put through a 30-step divide and
// loaded into the output register; the load waits while the sink holds a result.
// The block takes no new beat until the last one is through the single
// read-modify-write pass on the sum memory and, if it closed a box, the bit-serial divider.
// Reset and every write to a known register restart the frame and compute the
// column and row step sizes before the first beat is taken.
module area_average_downscaler
    import aad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    aad_pix_if.sink     pix,
    aad_res_if.source   res,
    aad_cfg_if.sink     cfg
);

    // Configuration registers
    logic [FMT_W-1:0]   fmt_reg;
    logic [SSIZE_W-1:0] sw_reg, sh_reg;
    logic [DSIZE_W-1:0] dw_reg, dh_reg;

    state_t state_reg, state_next;

    // Step sizes: src/dst quotient and remainder per axis
    logic [SSIZE_W-1:0]    qc_reg, qr_reg;
    logic [DSIZE_W-1:0]    rc_reg, rr_reg;
    logic [INIT_CNT_W-1:0] icnt_reg;

    // Position state
    logic [SPOS_W-1:0]  src_col_reg, src_row_reg, band_reg;
    logic [DPOS_W-1:0]  dst_col_reg, dst_row_reg;
    logic [SSIZE_W-1:0] col_start_reg, col_end_reg, row_end_reg;
    logic [DSIZE_W-1:0] col_rem_reg, row_rem_reg;

    // Latched pixel after swizzle
    logic [7:0] r_reg, g_reg, b_reg, a_reg;

    // Sum memory: four 30-bit channel sums per destination column
    logic [4*SUM_W-1:0] sum_mem [MAX_DST_W];
    logic [4*SUM_W-1:0] rd_data_reg;
    logic [4*SUM_W-1:0] wr_data;
    logic               mem_we;

    // Divider
    logic [CNT_W-1:0]     count_reg;
    logic [SUM_W-1:0]     num_reg [4];
    logic [CNT_W-1:0]     rem_reg [4];
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [DPOS_W-1:0]    ox_reg, oy_reg;
    logic                 ofe_reg;

    res_t out_reg;
    logic out_valid_reg;

    logic cfg_fire, cfg_restart, pix_fire, geom_ok, emit, load_out;

    assign cfg_fire = cfg.valid && cfg.ready;
    assign pix_fire = pix.valid && pix.ready;
    // Only a write to a known register restarts the frame
    assign cfg_restart = cfg_fire && (cfg.data.index <= CFG_IDX_W'(REG_DST_HEIGHT));

    assign geom_ok = (sw_reg != '0) && (sh_reg != '0) && (dw_reg != '0) && (dh_reg != '0)
        && (sw_reg <= SSIZE_W'(MAX_SRC_W)) && (sh_reg <= SSIZE_W'(MAX_SRC_H))
        && (dw_reg <= DSIZE_W'(MAX_DST_W)) && (dh_reg <= DSIZE_W'(MAX_DST_H))
        && (sw_reg >= SSIZE_W'(dw_reg)) && (sh_reg >= SSIZE_W'(dh_reg));

    // Per-beat accumulate decisions
    logic [SSIZE_W-1:0] src_col_p1, src_row_p1;
    logic               col_hit, row_hit, first_touch;
    logic [DSIZE_W:0]   col_rsum, row_rsum;
    logic               col_carry, row_carry;
    logic [SUM_W-1:0]   old_r, old_g, old_b, old_a;

    assign src_col_p1  = SSIZE_W'(src_col_reg) + SSIZE_W'(1);
    assign src_row_p1  = SSIZE_W'(src_row_reg) + SSIZE_W'(1);
    assign col_hit     = src_col_p1 >= col_end_reg;
    assign row_hit     = src_row_p1 >= row_end_reg;
    assign emit        = col_hit && row_hit;
    // The entry is stale until the first source pixel of its box lands: read it as zero
    assign first_touch = (src_row_reg == band_reg)
        && (SSIZE_W'(src_col_reg) == col_start_reg);
    assign col_rsum    = {1'b0, col_rem_reg} + {1'b0, rc_reg};
    assign row_rsum    = {1'b0, row_rem_reg} + {1'b0, rr_reg};
    assign col_carry   = col_rsum >= {1'b0, dw_reg};
    assign row_carry   = row_rsum >= {1'b0, dh_reg};

    assign old_r = first_touch ? '0 : rd_data_reg[4*SUM_W-1:3*SUM_W];
    assign old_g = first_touch ? '0 : rd_data_reg[3*SUM_W-1:2*SUM_W];
    assign old_b = first_touch ? '0 : rd_data_reg[2*SUM_W-1:SUM_W];
    assign old_a = first_touch ? '0 : rd_data_reg[SUM_W-1:0];

    assign wr_data = {old_r + SUM_W'(r_reg), old_g + SUM_W'(g_reg),
                      old_b + SUM_W'(b_reg), old_a + SUM_W'(a_reg)};

    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || res.ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: if (icnt_reg == INIT_CNT_W'(INIT_STEPS)) state_next = S_IDLE;
            S_IDLE: if (pix_fire && geom_ok) state_next = S_ACC;
            S_ACC:  state_next = emit ? S_DIV : S_IDLE;
            S_DIV:  if (dcnt_reg == DIV_CNT_W'(DIV_STEPS)) state_next = S_FIN;
            S_FIN:  if (load_out) state_next = S_IDLE;
            default: state_next = S_INIT;
        endcase
        if (cfg_restart)
        begin
            state_next = S_INIT;
        end
    end

    // Outputs of the controller
    always_comb
    begin
        pix.ready = 1'b0;
        mem_we    = 1'b0;
        unique case (state_reg)
            S_IDLE: pix.ready = 1'b1;
            S_ACC:  mem_we    = 1'b1;
            default: ;
        endcase
    end

    assign cfg.ready = 1'b1;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sum memory: one read and one write port, read data registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= sum_mem[dst_col_reg];
        if (mem_we)
        begin
            sum_mem[dst_col_reg] <= wr_data;
        end
    end

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_W'(FMT_RGBA);
            sw_reg  <= SSIZE_W'(640);
            sh_reg  <= SSIZE_W'(480);
            dw_reg  <= DSIZE_W'(320);
            dh_reg  <= DSIZE_W'(240);
        end
        else if (cfg_fire)
        begin
            unique case (cfg.data.index)
                REG_PIXEL_FORMAT: fmt_reg <= cfg.data.data[FMT_W-1:0];
                REG_SRC_WIDTH:    sw_reg  <= cfg.data.data[SSIZE_W-1:0];
                REG_SRC_HEIGHT:   sh_reg  <= cfg.data.data[SSIZE_W-1:0];
                REG_DST_WIDTH:    dw_reg  <= cfg.data.data[DSIZE_W-1:0];
                REG_DST_HEIGHT:   dh_reg  <= cfg.data.data[DSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Step-size dividers, one quotient bit per cycle on each axis
    logic [SSIZE_W-1:0] sw_sh_reg, sh_sh_reg;
    logic [SSIZE_W-1:0] sw_src, sh_src;
    logic [DSIZE_W:0]   ic_dv, ir_dv;

    // The first step takes its dividend bits straight from the size registers
    assign sw_src = (icnt_reg == '0) ? sw_reg : sw_sh_reg;
    assign sh_src = (icnt_reg == '0) ? sh_reg : sh_sh_reg;
    assign ic_dv  = {rc_reg, sw_src[SSIZE_W-1]};
    assign ir_dv  = {rr_reg, sh_src[SSIZE_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icnt_reg  <= '0;
            qc_reg    <= '0;
            qr_reg    <= '0;
            rc_reg    <= '0;
            rr_reg    <= '0;
            sw_sh_reg <= '0;
            sh_sh_reg <= '0;
        end
        else if (cfg_restart)
        begin
            // Start the step-size division over from the new sizes
            icnt_reg <= '0;
            qc_reg   <= '0;
            qr_reg   <= '0;
            rc_reg   <= '0;
            rr_reg   <= '0;
        end
        else if (state_reg == S_INIT && icnt_reg != INIT_CNT_W'(INIT_STEPS))
        begin
            icnt_reg  <= icnt_reg + INIT_CNT_W'(1);
            sw_sh_reg <= {sw_src[SSIZE_W-2:0], 1'b0};
            sh_sh_reg <= {sh_src[SSIZE_W-2:0], 1'b0};
            if (ic_dv >= {1'b0, dw_reg})
            begin
                rc_reg <= DSIZE_W'(ic_dv - {1'b0, dw_reg});
                qc_reg <= {qc_reg[SSIZE_W-2:0], 1'b1};
            end
            else
            begin
                rc_reg <= DSIZE_W'(ic_dv);
                qc_reg <= {qc_reg[SSIZE_W-2:0], 1'b0};
            end
            if (ir_dv >= {1'b0, dh_reg})
            begin
                rr_reg <= DSIZE_W'(ir_dv - {1'b0, dh_reg});
                qr_reg <= {qr_reg[SSIZE_W-2:0], 1'b1};
            end
            else
            begin
                rr_reg <= DSIZE_W'(ir_dv);
                qr_reg <= {qr_reg[SSIZE_W-2:0], 1'b0};
            end
        end
    end

    // Position counters, pixel latch and box bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            band_reg      <= '0;
            dst_col_reg   <= '0;
            dst_row_reg   <= '0;
            col_start_reg <= '0;
            col_end_reg   <= '0;
            row_end_reg   <= '0;
            col_rem_reg   <= '0;
            row_rem_reg   <= '0;
        end
        else if (state_reg == S_INIT)
        begin
            // Restart the frame once the step sizes are known
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            band_reg      <= '0;
            dst_col_reg   <= '0;
            dst_row_reg   <= '0;
            col_start_reg <= '0;
            col_end_reg   <= qc_reg;
            row_end_reg   <= qr_reg;
            col_rem_reg   <= rc_reg;
            row_rem_reg   <= rr_reg;
        end
        else if (state_reg == S_ACC)
        begin
            if (col_hit)
            begin
                dst_col_reg   <= dst_col_reg + DPOS_W'(1);
                col_start_reg <= col_end_reg;
                col_end_reg   <= col_end_reg + qc_reg + SSIZE_W'(col_carry);
                col_rem_reg   <= col_carry ? DSIZE_W'(col_rsum - {1'b0, dw_reg})
                                           : DSIZE_W'(col_rsum);
            end
            src_col_reg <= SPOS_W'(src_col_p1);
            if (src_col_p1 >= sw_reg)
            begin
                // End of a source row: rewind the columns
                src_col_reg   <= '0;
                dst_col_reg   <= '0;
                col_start_reg <= '0;
                col_end_reg   <= qc_reg;
                col_rem_reg   <= rc_reg;
                src_row_reg   <= SPOS_W'(src_row_p1);
                if (row_hit)
                begin
                    dst_row_reg <= dst_row_reg + DPOS_W'(1);
                    band_reg    <= SPOS_W'(src_row_p1);
                    row_end_reg <= row_end_reg + qr_reg + SSIZE_W'(row_carry);
                    row_rem_reg <= row_carry ? DSIZE_W'(row_rsum - {1'b0, dh_reg})
                                             : DSIZE_W'(row_rsum);
                end
                if (src_row_p1 >= sh_reg
                    || (row_hit && (DSIZE_W'(dst_row_reg) + DSIZE_W'(1) >= dh_reg)))
                begin
                    src_row_reg <= '0;
                    dst_row_reg <= '0;
                    band_reg    <= '0;
                    row_end_reg <= qr_reg;
                    row_rem_reg <= rr_reg;
                end
            end
        end
    end

    // Swizzle at acceptance
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            case (fmt_reg) inside
                FMT_RGB, FMT_RGBX:
                begin
                    r_reg <= pix.data.byte_0;
                    g_reg <= pix.data.byte_1;
                    b_reg <= pix.data.byte_2;
                    a_reg <= OPAQUE;
                end
                FMT_BGRA:
                begin
                    r_reg <= pix.data.byte_2;
                    g_reg <= pix.data.byte_1;
                    b_reg <= pix.data.byte_0;
                    a_reg <= pix.data.byte_3;
                end
                FMT_BGRX:
                begin
                    r_reg <= pix.data.byte_2;
                    g_reg <= pix.data.byte_1;
                    b_reg <= pix.data.byte_0;
                    a_reg <= OPAQUE;
                end
                default:
                begin
                    r_reg <= pix.data.byte_0;
                    g_reg <= pix.data.byte_1;
                    b_reg <= pix.data.byte_2;
                    a_reg <= pix.data.byte_3;
                end
            endcase
        end
    end

    // Box size and bit-serial mean, four channels side by side
    logic [CNT_W-1:0] cnt_raw;
    assign cnt_raw = CNT_W'(col_end_reg - col_start_reg) * CNT_W'(row_end_reg - SSIZE_W'(band_reg));

    logic [CNT_W:0] dt [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dt[i] = {rem_reg[i], num_reg[i][SUM_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (state_reg == S_ACC)
        begin
            dcnt_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ACC)
        begin
            count_reg  <= (cnt_raw == '0) ? CNT_W'(1) : cnt_raw;
            num_reg[0] <= wr_data[4*SUM_W-1:3*SUM_W];
            num_reg[1] <= wr_data[3*SUM_W-1:2*SUM_W];
            num_reg[2] <= wr_data[2*SUM_W-1:SUM_W];
            num_reg[3] <= wr_data[SUM_W-1:0];
            for (int i = 0; i < 4; i++)
            begin
                rem_reg[i] <= '0;
            end
            ox_reg  <= dst_col_reg;
            oy_reg  <= dst_row_reg;
            ofe_reg <= (DSIZE_W'(dst_col_reg) + DSIZE_W'(1) == dw_reg)
                    && (DSIZE_W'(dst_row_reg) + DSIZE_W'(1) == dh_reg);
        end
        else if (state_reg == S_DIV && dcnt_reg != DIV_CNT_W'(DIV_STEPS))
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (dt[i] >= {1'b0, count_reg})
                begin
                    rem_reg[i] <= CNT_W'(dt[i] - {1'b0, count_reg});
                    num_reg[i] <= {num_reg[i][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= CNT_W'(dt[i]);
                    num_reg[i] <= {num_reg[i][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Output register: hold the result until the sink takes the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.out_red   <= num_reg[0][7:0];
            out_reg.out_green <= num_reg[1][7:0];
            out_reg.out_blue  <= num_reg[2][7:0];
            out_reg.out_alpha <= num_reg[3][7:0];
            out_reg.out_x     <= ox_reg;
            out_reg.out_y     <= oy_reg;
            out_reg.frame_end <= ofe_reg;
        end
    end

    // The input side only opens between items
    assert property (@(posedge clk) disable iff (!rst_n)
        pix.ready |-> (state_reg == S_IDLE))
        else $error("input ready outside idle");

    // Column positions stay inside the frame between beats
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && geom_ok) |-> (DSIZE_W'(dst_col_reg) < dw_reg
            && SSIZE_W'(src_col_reg) < sw_reg))
        else $error("column position out of frame");

    // The mean never runs with an empty box
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (count_reg != '0))
        else $error("zero box size in divider");

endmodule

// ----- verif/aad_checker.sv -----
module aad_checker
    import aad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    aad_pix_if.monitor  pix_mon,
    aad_res_if.monitor  res_mon,
    aad_cfg_if.monitor  cfg_mon,
    output int          fail_count,
    output int          pending_count,
    output int          pixel_count,
    output int          result_count
);

    logic [2:0]  fmt_q;
    logic [11:0] sw_q, sh_q;
    logic [9:0]  dw_q, dh_q;

    logic [29:0] red_acc [MAX_DST_W];
    logic [29:0] grn_acc [MAX_DST_W];
    logic [29:0] blu_acc [MAX_DST_W];
    logic [29:0] alp_acc [MAX_DST_W];
    int unsigned src_col, src_row, dst_col, dst_row, band_top;

    res_t expected_pixels [$];

    task automatic restart_frame();
        for (int i = 0; i < MAX_DST_W; i++)
        begin
            red_acc[i] = '0;
            grn_acc[i] = '0;
            blu_acc[i] = '0;
            alp_acc[i] = '0;
        end
        src_col = 0;
        src_row = 0;
        dst_col = 0;
        dst_row = 0;
        band_top = 0;
    endtask

    function automatic bit geometry_ok();
        if (sw_q == 0 || sh_q == 0 || dw_q == 0 || dh_q == 0)
            return 0;
        if (sw_q > MAX_SRC_W || sh_q > MAX_SRC_H || dw_q > MAX_DST_W || dh_q > MAX_DST_H)
            return 0;
        return sw_q >= dw_q && sh_q >= dh_q;
    endfunction

    // Accumulate one source pixel and queue the destination pixel it closes.
    task automatic average_pixel(input pix_t p);
        logic [7:0] r, g, b, a;
        int unsigned c0, c1, r1, n;
        res_t e;
        if (!geometry_ok())
            return;
        if (dst_col >= dw_q)
            dst_col = 0;
        case (fmt_q) inside
            FMT_RGB, FMT_RGBX:
            begin
                r = p.byte_0; g = p.byte_1; b = p.byte_2; a = OPAQUE;
            end
            FMT_BGRA:
            begin
                r = p.byte_2; g = p.byte_1; b = p.byte_0; a = p.byte_3;
            end
            FMT_BGRX:
            begin
                r = p.byte_2; g = p.byte_1; b = p.byte_0; a = OPAQUE;
            end
            default:
            begin
                r = p.byte_0; g = p.byte_1; b = p.byte_2; a = p.byte_3;
            end
        endcase
        red_acc[dst_col] += r;
        grn_acc[dst_col] += g;
        blu_acc[dst_col] += b;
        alp_acc[dst_col] += a;
        c0 = (dst_col * sw_q) / dw_q;
        c1 = ((dst_col + 1) * sw_q) / dw_q;
        r1 = ((dst_row + 1) * sh_q) / dh_q;
        if (src_col + 1 >= c1)
        begin
            if (src_row + 1 >= r1)
            begin
                n = (c1 - c0) * (r1 - band_top);
                if (n == 0)
                    n = 1;
                e.out_red   = 8'(red_acc[dst_col] / n);
                e.out_green = 8'(grn_acc[dst_col] / n);
                e.out_blue  = 8'(blu_acc[dst_col] / n);
                e.out_alpha = 8'(alp_acc[dst_col] / n);
                e.out_x     = 9'(dst_col);
                e.out_y     = 9'(dst_row);
                e.frame_end = (dst_col + 1 == dw_q) && (dst_row + 1 == dh_q);
                red_acc[dst_col] = '0;
                grn_acc[dst_col] = '0;
                blu_acc[dst_col] = '0;
                alp_acc[dst_col] = '0;
                expected_pixels = {expected_pixels, e};
            end
            dst_col++;
        end
        src_col++;
        if (src_col >= sw_q)
        begin
            src_col = 0;
            dst_col = 0;
            src_row++;
            if (src_row >= r1)
            begin
                dst_row++;
                band_top = src_row;
            end
            if (src_row >= sh_q || dst_row >= dh_q)
            begin
                src_row = 0;
                dst_row = 0;
                band_top = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
        begin
            fmt_q = FMT_RGBA;
            sw_q = 12'd640;
            sh_q = 12'd480;
            dw_q = 10'd320;
            dh_q = 10'd240;
            restart_frame();
            expected_pixels.delete();
            fail_count <= 0;
            pixel_count <= 0;
            result_count <= 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_idx_t'(cfg_mon.data.index))
                    REG_PIXEL_FORMAT: fmt_q = cfg_mon.data.data[2:0];
                    REG_SRC_WIDTH:    sw_q = cfg_mon.data.data;
                    REG_SRC_HEIGHT:   sh_q = cfg_mon.data.data;
                    REG_DST_WIDTH:    dw_q = cfg_mon.data.data[9:0];
                    REG_DST_HEIGHT:   dh_q = cfg_mon.data.data[9:0];
                    default:;
                endcase
                // Writes to unknown indexes leave the frame running
                if (cfg_mon.data.index <= REG_DST_HEIGHT)
                    restart_frame();
            end
            if (pix_mon.valid && pix_mon.ready)
            begin
                average_pixel(pix_mon.data);
                pixel_count <= pixel_count + 1;
            end
            if (res_mon.valid && res_mon.ready)
            begin
                result_count <= result_count + 1;
                if (expected_pixels.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result beat %p", res_mon.data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_pixels.pop_front();
                    if (res_mon.data !== e)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p, got %p", e, res_mon.data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count <= expected_pixels.size();
    end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    import aad_pkg::*;

    logic clk;
    logic rst_n;

    aad_pix_if pix ();
    aad_res_if res ();
    aad_cfg_if cfg ();

    int fail_count, pending_count, pixel_count, result_count;

    // Idle percentages for sender and receiver, changed between phases.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // A nonzero value makes the receiver hold off for that many cycles.
    int unsigned hold_off_cycles;
    int unsigned frames_run;

    area_average_downscaler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    aad_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_mon       (pix.monitor),
        .res_mon       (res.monitor),
        .cfg_mon       (cfg.monitor),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .pixel_count   (pixel_count),
        .result_count  (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // Receiver: random ready, with one long hold-off in the last phase so the block backs up.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                res.ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                res.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Give up after a generous fixed time.
    initial
    begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one pixel beat and hold it until accepted, idling at random first.
    task automatic send_pixel(input pix_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.data  <= p;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
    endtask

    function automatic pix_t random_pixel();
        pix_t p;
        p = $urandom;
        if ($urandom_range(9) == 0)
            p = $urandom_range(1) ? '1 : '0;
        return p;
    endfunction

    // Offer one register write and wait until it is taken; the caller drops valid.
    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        cfg.valid <= 1'b1;
        cfg.data  <= '{index: idx, data: value[11:0]};
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    // Drain pending results, then let the in-flight work finish.
    task automatic wait_idle();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic set_geometry(input fmt_t fmt, input int unsigned sw, input int unsigned sh,
                                input int unsigned dw, input int unsigned dh);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, fmt);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_frames(input int unsigned n_pixels);
        repeat (n_pixels)
            send_pixel(random_pixel());
    endtask

    initial
    begin
        int unsigned sw, sh, dw, dh, total, n;
        fmt_t fmt;
        rst_n = 1'b0;
        pix.valid = 1'b0;
        pix.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 0;
        frames_run = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme bytes in RGB at 2:1, then every other format on a tiny frame at 1:1.
        set_geometry(FMT_RGB, 2, 2, 1, 1);
        send_pixel('1);
        send_pixel('0);
        send_pixel(32'hff00ff00);
        send_pixel(32'h00ff00ff);
        for (int f = FMT_RGBA; f <= FMT_BGRX; f++)
        begin
            set_geometry(fmt_t'(f), 2, 1, 2, 1);
            send_pixel(32'h12345678);
            send_pixel(32'hfedcba98);
        end
        // Unsupported formats behave as RGBA.
        set_geometry(fmt_t'(3'd7), 1, 1, 1, 1);
        send_pixel(32'h01020304);
        // Smaller source than destination: beats are dropped.
        set_geometry(FMT_RGBA, 2, 2, 3, 1);
        send_pixel(random_pixel());
        send_pixel(random_pixel());
        // Uneven ratio with frame wrap.
        set_geometry(FMT_BGRA, 5, 3, 2, 2);
        send_frames(15);
        frames_run = 8;

        // Random: mostly small frames and a few wide ones near the width limits.
        total = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 77 : 0;
            recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 25 : 0;
            if (phase == 2)
            begin
                // Hold the receiver off while a many-result frame streams in
                set_geometry(FMT_RGBA, 8, 4, 4, 2);
                hold_off_cycles = 400;
                send_frames(64);
                total += 64;
                frames_run++;
            end
            while (total < 650 * (phase + 1))
            begin
                fmt = fmt_t'($urandom_range(4));
                if ($urandom_range(19) == 0)
                begin
                    // Wide line near the limits, only the leading part of the row
                    sw = $urandom_range(2048, 600);
                    dw = $urandom_range(512, 500);
                    sh = 1;
                    dh = 1;
                    n = $urandom_range(256, 64);
                end
                else
                begin
                    sw = $urandom_range(12, 1);
                    sh = $urandom_range(8, 1);
                    dw = $urandom_range(sw, 1);
                    dh = $urandom_range(sh, 1);
                    n = sw * sh * $urandom_range(2, 1);
                end
                set_geometry(fmt, sw, sh, dw, dh);
                send_frames(n);
                total += n;
                frames_run++;
            end
        end

        wait_idle();
        repeat (100)
            @(posedge clk);
        $display("covered %0d geometries: %0d pixel beats in, %0d result beats out",
                 frames_run, pixel_count, result_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
